// ----- rtl/bfsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfsa_pkg
// Shared types and codes for the best-fit slot allocator.
// ----------------------------------------------------------------------------
package bfsa_pkg;

   localparam int ADDR_W = 32;
   localparam int LEN_W  = 26;
   localparam int SIZE_W = 27;
   localparam int STAT_W = 3;
   localparam int SIDX_W = 3;
   localparam int CSR_W  = 2;

   localparam logic [SIZE_W-1:0] ALIGN_LOW = SIZE_W'(31);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STAT_W-1:0] ST_RECYCLED = 3'd0;
   localparam logic [STAT_W-1:0] ST_NEW      = 3'd1;
   localparam logic [STAT_W-1:0] ST_NONE     = 3'd2;
   localparam logic [STAT_W-1:0] ST_FREED    = 3'd3;
   localparam logic [STAT_W-1:0] ST_MISS     = 3'd4;

   localparam logic [CSR_W-1:0] CSR_POOL_BASE = 2'd0;
   localparam logic [CSR_W-1:0] CSR_POOL_SIZE = 2'd1;

   typedef struct packed {
      logic              opcode;
      logic [LEN_W-1:0]  length;
      logic [ADDR_W-1:0] address;
   } req_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0] result_address;
      logic [STAT_W-1:0] status;
      logic [SIDX_W-1:0] slot_index;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_FINISH = 4'b0100,
      S_RESP   = 4'b1000
   } state_type;

endpackage

// ----- rtl/bfsa_ram.sv -----
// ----------------------------------------------------------------------------
// bfsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/best_fit_slot_allocator_top.sv -----
// ----------------------------------------------------------------------------
// best_fit_slot_allocator_top
// Best-fit recycling of buffer slots, backed by a bump pool carved in 32-byte units.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall| bfsa_pkg::req_payload_type
//   rsp     | out       | rsp_valid/rsp_stall| bfsa_pkg::rsp_payload_type
//   csr     | in        | csr_valid/csr_ready| csr_index, csr_data
//
// One slot compare per cycle through a shared compare unit: after the scan, a finish
// state registers the result, which then waits in the response state through any rsp
// stall; the next request is taken once that result has transferred.
// The slot tables sit in registered-read RAMs, so each slot is compared in the cycle
// after its read address. Synchronous reset clears slot valid/busy bits and the pool.
// req_stall stays high from a transfer until its result transfers.
// ----------------------------------------------------------------------------
module best_fit_slot_allocator_top #(
   parameter int SLOT_COUNT = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  bfsa_pkg::req_payload_type       req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output bfsa_pkg::rsp_payload_type       rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bfsa_pkg::CSR_W-1:0]      csr_index,
   input  logic [bfsa_pkg::ADDR_W-1:0]     csr_data
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   bfsa_pkg::state_type state_ff, state_in;

   logic                        opcode_ff, opcode_in;
   logic [bfsa_pkg::LEN_W-1:0]  length_ff, length_in;
   logic [bfsa_pkg::ADDR_W-1:0] address_ff, address_in;
   logic [bfsa_pkg::SIZE_W-1:0] rounded_ff, rounded_in;

   logic [IDX_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic             issue_done_ff, issue_done_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;

   logic                        found_ff, found_in;
   logic [IDX_W-1:0]            best_idx_ff, best_idx_in;
   logic [bfsa_pkg::LEN_W-1:0]  best_bytes_ff, best_bytes_in;
   logic [bfsa_pkg::ADDR_W-1:0] best_start_ff, best_start_in;
   logic                        empty_found_ff, empty_found_in;
   logic [IDX_W-1:0]            empty_idx_ff, empty_idx_in;

   logic [SLOT_COUNT-1:0] slot_valid_ff, slot_valid_in;
   logic [SLOT_COUNT-1:0] slot_busy_ff, slot_busy_in;

   logic [bfsa_pkg::ADDR_W-1:0] bump_next_ff, bump_next_in;
   logic [bfsa_pkg::SIZE_W-1:0] bump_left_ff, bump_left_in;
   logic [bfsa_pkg::SIZE_W-1:0] pool_size_ff, pool_size_in;

   logic [bfsa_pkg::ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [bfsa_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]            rsp_idx_ff, rsp_idx_in;

   logic                        ram_wr_en;
   logic [bfsa_pkg::ADDR_W-1:0] start_q;
   logic [bfsa_pkg::LEN_W-1:0]  bytes_q;
   logic                        cur_valid;
   logic                        cur_busy;
   logic                        hit_free;
   logic                        hit_fit;
   logic                        grant_new;
   logic [IDX_W+2:0]            rsp_idx_ext;

   assign req_stall = (state_ff != bfsa_pkg::S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == bfsa_pkg::S_RESP);

   assign rsp_idx_ext               = {3'b000, rsp_idx_ff};
   assign rsp_data.result_address   = rsp_addr_ff;
   assign rsp_data.status           = rsp_status_ff;
   assign rsp_data.slot_index       = rsp_idx_ext[2:0];

   bfsa_ram #(
      .WIDTH (bfsa_pkg::ADDR_W),
      .DEPTH (SLOT_COUNT),
      .AW    (IDX_W)
   ) u_start_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (empty_idx_ff),
      .wr_data (bump_next_ff),
      .rd_addr (scan_cnt_ff),
      .rd_data (start_q)
   );

   bfsa_ram #(
      .WIDTH (bfsa_pkg::LEN_W),
      .DEPTH (SLOT_COUNT),
      .AW    (IDX_W)
   ) u_bytes_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (empty_idx_ff),
      .wr_data (length_ff),
      .rd_addr (scan_cnt_ff),
      .rd_data (bytes_q)
   );

   assign cur_valid = slot_valid_ff[cmp_idx_ff];
   assign cur_busy  = slot_busy_ff[cmp_idx_ff];
   assign hit_free  = cur_valid && (start_q == address_ff) && !found_ff;
   assign hit_fit   = cur_valid && !cur_busy && (bytes_q >= length_ff) &&
                      (!found_ff || (bytes_q < best_bytes_ff));
   assign grant_new = (opcode_ff == bfsa_pkg::OP_ALLOC) && !found_ff && empty_found_ff &&
                      (pool_size_ff != '0) && (rounded_ff <= bump_left_ff);
   assign ram_wr_en = (state_ff == bfsa_pkg::S_FINISH) && grant_new;

   always_comb begin
      state_in       = state_ff;
      opcode_in      = opcode_ff;
      length_in      = length_ff;
      address_in     = address_ff;
      rounded_in     = rounded_ff;
      scan_cnt_in    = scan_cnt_ff;
      issue_done_in  = issue_done_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = scan_cnt_ff;
      found_in       = found_ff;
      best_idx_in    = best_idx_ff;
      best_bytes_in  = best_bytes_ff;
      best_start_in  = best_start_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      slot_valid_in  = slot_valid_ff;
      slot_busy_in   = slot_busy_ff;
      bump_next_in   = bump_next_ff;
      bump_left_in   = bump_left_ff;
      pool_size_in   = pool_size_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_idx_in     = rsp_idx_ff;

      case (state_ff)
         bfsa_pkg::S_IDLE: begin
            if (req_valid) begin
               opcode_in      = req_data.opcode;
               length_in      = req_data.length;
               address_in     = req_data.address;
               rounded_in     = ({1'b0, req_data.length} + bfsa_pkg::ALIGN_LOW) &
                                ~bfsa_pkg::ALIGN_LOW;
               scan_cnt_in    = '0;
               issue_done_in  = 1'b0;
               found_in       = 1'b0;
               empty_found_in = 1'b0;
               best_idx_in    = '0;
               empty_idx_in   = '0;
               state_in       = bfsa_pkg::S_SCAN;
            end
         end
         bfsa_pkg::S_SCAN: begin
            if (!issue_done_ff) begin
               cmp_vld_in = 1'b1;
               if (scan_cnt_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end else begin
                  scan_cnt_in = scan_cnt_ff + 1'b1;
               end
            end
            if (cmp_vld_ff) begin
               if (opcode_ff == bfsa_pkg::OP_FREE) begin
                  if (hit_free) begin
                     found_in    = 1'b1;
                     best_idx_in = cmp_idx_ff;
                  end
               end else begin
                  if (hit_fit) begin
                     found_in      = 1'b1;
                     best_idx_in   = cmp_idx_ff;
                     best_bytes_in = bytes_q;
                     best_start_in = start_q;
                  end
                  if (!cur_valid && !empty_found_ff) begin
                     empty_found_in = 1'b1;
                     empty_idx_in   = cmp_idx_ff;
                  end
               end
               if (cmp_idx_ff == LAST_IDX) begin
                  state_in = bfsa_pkg::S_FINISH;
               end
            end
         end
         bfsa_pkg::S_FINISH: begin
            rsp_addr_in = '0;
            rsp_idx_in  = '0;
            if (opcode_ff == bfsa_pkg::OP_FREE) begin
               if (found_ff) begin
                  slot_busy_in[best_idx_ff] = 1'b0;
                  rsp_status_in             = bfsa_pkg::ST_FREED;
                  rsp_idx_in                = best_idx_ff;
               end else begin
                  rsp_status_in = bfsa_pkg::ST_MISS;
               end
            end else if (found_ff) begin
               slot_busy_in[best_idx_ff] = 1'b1;
               rsp_addr_in               = best_start_ff;
               rsp_status_in             = bfsa_pkg::ST_RECYCLED;
               rsp_idx_in                = best_idx_ff;
            end else if (grant_new) begin
               slot_valid_in[empty_idx_ff] = 1'b1;
               slot_busy_in[empty_idx_ff]  = 1'b1;
               bump_next_in  = bump_next_ff + {5'b00000, rounded_ff};
               bump_left_in  = bump_left_ff - rounded_ff;
               rsp_addr_in   = bump_next_ff;
               rsp_status_in = bfsa_pkg::ST_NEW;
               rsp_idx_in    = empty_idx_ff;
            end else begin
               rsp_status_in = bfsa_pkg::ST_NONE;
            end
            state_in = bfsa_pkg::S_RESP;
         end
         bfsa_pkg::S_RESP: begin
            if (!rsp_stall) begin
               state_in = bfsa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bfsa_pkg::S_IDLE;
         end
      endcase

      if (csr_valid && csr_ready) begin
         case (csr_index)
            bfsa_pkg::CSR_POOL_BASE: begin
               bump_next_in = csr_data;
            end
            bfsa_pkg::CSR_POOL_SIZE: begin
               pool_size_in = csr_data[bfsa_pkg::SIZE_W-1:0];
               bump_left_in = csr_data[bfsa_pkg::SIZE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bfsa_pkg::S_IDLE;
         issue_done_ff <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         slot_valid_ff <= '0;
         slot_busy_ff  <= '0;
         bump_next_ff  <= '0;
         bump_left_ff  <= '0;
         pool_size_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         issue_done_ff <= issue_done_in;
         cmp_vld_ff    <= cmp_vld_in;
         slot_valid_ff <= slot_valid_in;
         slot_busy_ff  <= slot_busy_in;
         bump_next_ff  <= bump_next_in;
         bump_left_ff  <= bump_left_in;
         pool_size_ff  <= pool_size_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff      <= opcode_in;
      length_ff      <= length_in;
      address_ff     <= address_in;
      rounded_ff     <= rounded_in;
      scan_cnt_ff    <= scan_cnt_in;
      cmp_idx_ff     <= cmp_idx_in;
      found_ff       <= found_in;
      best_idx_ff    <= best_idx_in;
      best_bytes_ff  <= best_bytes_in;
      best_start_ff  <= best_start_in;
      empty_found_ff <= empty_found_in;
      empty_idx_ff   <= empty_idx_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_idx_ff     <= rsp_idx_in;
   end

   a_no_accept_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a result is pending");

   a_pool_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfsa_pkg::S_FINISH && grant_new && !(csr_valid && csr_ready)) |=>
      (bump_left_ff == $past(bump_left_ff) - $past(rounded_ff)))
      else $error("pool did not shrink by the rounded length");

   a_recycled_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status_ff == bfsa_pkg::ST_RECYCLED) |->
      (slot_valid_ff[rsp_idx_ff] && slot_busy_ff[rsp_idx_ff]))
      else $error("recycled slot not marked busy");

   a_freed_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status_ff == bfsa_pkg::ST_FREED) |->
      (slot_valid_ff[rsp_idx_ff] && !slot_busy_ff[rsp_idx_ff]))
      else $error("freed slot still busy");

endmodule

// ----- tb/sv/slot_grant_checker.sv -----
// ----------------------------------------------------------------------------
// slot_grant_checker
// Watches the request, result and register channels of the best-fit slot
// allocator. It keeps its own copy of the slot table and bump pool and
// computes the expected grant for every accepted request. Each result
// transfer is then compared field by field with the oldest expected grant.
// ----------------------------------------------------------------------------
module slot_grant_checker #(
   parameter int SLOT_COUNT = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  bfsa_pkg::req_payload_type       req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  bfsa_pkg::rsp_payload_type       rsp_data,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [bfsa_pkg::CSR_W-1:0]      csr_index,
   input  logic [bfsa_pkg::ADDR_W-1:0]     csr_data,
   output int                              fail_count,
   output int                              outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIDX_W = bfsa_pkg::SIDX_W;

   logic                        slot_live [SLOT_COUNT];
   logic                        slot_held [SLOT_COUNT];
   logic [bfsa_pkg::ADDR_W-1:0] slot_addr [SLOT_COUNT];
   logic [bfsa_pkg::LEN_W-1:0]  slot_len  [SLOT_COUNT];
   logic [bfsa_pkg::SIZE_W-1:0] pool_bytes;
   logic [bfsa_pkg::ADDR_W-1:0] pool_next;
   logic [bfsa_pkg::SIZE_W-1:0] pool_left;

   bfsa_pkg::rsp_payload_type   due_grants[$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   function automatic bfsa_pkg::rsp_payload_type serve_request(
      bfsa_pkg::req_payload_type item);
      bfsa_pkg::rsp_payload_type   res;
      logic                        found;
      int                          best;
      logic [bfsa_pkg::SIZE_W-1:0] rounded;
      res   = '0;
      found = 1'b0;
      best  = 0;
      if (item.opcode == bfsa_pkg::OP_FREE) begin
         res.status = bfsa_pkg::ST_MISS;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_live[i] && slot_addr[i] == item.address) begin
               slot_held[i]   = 1'b0;
               res.status     = bfsa_pkg::ST_FREED;
               res.slot_index = SIDX_W'(i);
               return res;
            end
         end
         return res;
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (slot_live[i] && !slot_held[i] && slot_len[i] >= item.length &&
             (!found || slot_len[i] < slot_len[best])) begin
            found = 1'b1;
            best  = i;
         end
      end
      if (found) begin
         slot_held[best]    = 1'b1;
         res.result_address = slot_addr[best];
         res.status         = bfsa_pkg::ST_RECYCLED;
         res.slot_index     = SIDX_W'(best);
         return res;
      end
      res.status = bfsa_pkg::ST_NONE;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (!slot_live[i]) begin
            rounded = ({1'b0, item.length} + bfsa_pkg::ALIGN_LOW) &
                      ~bfsa_pkg::ALIGN_LOW;
            if (pool_bytes == '0 || rounded > pool_left) begin
               return res;
            end
            res.result_address = pool_next;
            res.status         = bfsa_pkg::ST_NEW;
            res.slot_index     = SIDX_W'(i);
            pool_next          = pool_next + {5'b00000, rounded};
            pool_left          = pool_left - rounded;
            slot_live[i]       = 1'b1;
            slot_held[i]       = 1'b1;
            slot_addr[i]       = res.result_address;
            slot_len[i]        = item.length;
            return res;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      bfsa_pkg::rsp_payload_type want;
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_live[i] = 1'b0;
            slot_held[i] = 1'b0;
            slot_addr[i] = '0;
            slot_len[i]  = '0;
         end
         pool_bytes  = '0;
         pool_next   = '0;
         pool_left   = '0;
         due_grants.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == bfsa_pkg::CSR_POOL_BASE) begin
               pool_next   = csr_data;
            end else if (csr_index == bfsa_pkg::CSR_POOL_SIZE) begin
               pool_bytes = csr_data[bfsa_pkg::SIZE_W-1:0];
               pool_left  = csr_data[bfsa_pkg::SIZE_W-1:0];
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_grants.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: unexpected result addr %h status %0d slot %0d",
                           $realtime, rsp_data.result_address, rsp_data.status,
                           rsp_data.slot_index);
               end
            end else begin
               want = due_grants.pop_front();
               if (rsp_data.result_address !== want.result_address ||
                   rsp_data.status !== want.status ||
                   rsp_data.slot_index !== want.slot_index) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: expected %h/%0d/%0d, got %h/%0d/%0d",
                              $realtime, want.result_address, want.status,
                              want.slot_index, rsp_data.result_address,
                              rsp_data.status, rsp_data.slot_index);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            due_grants.push_back(serve_request(req_data));
         end
      end
      outstanding <= due_grants.size();
   end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives allocate and free requests and pool register writes into the
// best-fit slot allocator with random gaps and result stalls, including one
// long result hold-off. A directed opening covers no pool, zero-length
// requests, pool exhaustion, address wrap, ties and repeated frees; random
// phases under several pool settings follow. The checker gives the verdict
// data.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEN_W = bfsa_pkg::LEN_W;
   localparam logic [bfsa_pkg::CSR_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [bfsa_pkg::CSR_W-1:0] CSR_SPARE_HI = 2'd3;
   localparam int               SETTLE_CYCLES = 16;
   localparam int               HOLD_CYCLES   = 300;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid;
   logic                        req_stall;
   bfsa_pkg::req_payload_type   req_data;
   logic                        rsp_valid;
   logic                        rsp_stall;
   bfsa_pkg::rsp_payload_type   rsp_data;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [bfsa_pkg::CSR_W-1:0]  csr_index;
   logic [bfsa_pkg::ADDR_W-1:0] csr_data;

   int                          fail_count;
   int                          outstanding;
   int                          sent_count = 0;
   bit                          calm = 1'b0;
   bit                          hold_rsp = 1'b0;
   logic [bfsa_pkg::ADDR_W-1:0] granted_addrs[$];

   always #5 clock = ~clock;

   best_fit_slot_allocator_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   slot_grant_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   task automatic offer_request(input logic op, input logic [LEN_W-1:0] len,
                                input logic [bfsa_pkg::ADDR_W-1:0] addr);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= '{opcode: op, length: len, address: addr};
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sent_count++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [bfsa_pkg::CSR_W-1:0] idx,
                            input logic [bfsa_pkg::ADDR_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : receiver
      int gap;
      bit known;
      rsp_stall <= 1'b0;
      wait (!reset);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         gap = calm ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         if (rsp_data.status == bfsa_pkg::ST_NEW ||
             rsp_data.status == bfsa_pkg::ST_RECYCLED) begin
            known = 1'b0;
            foreach (granted_addrs[k]) begin
               if (granted_addrs[k] == rsp_data.result_address) known = 1'b1;
            end
            if (!known) granted_addrs.push_back(rsp_data.result_address);
         end
      end
   end

   initial begin : long_hold
      wait (sent_count >= 300);
      hold_rsp = 1'b1;
   end

   initial begin : watchdog
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      logic [bfsa_pkg::ADDR_W-1:0] addr;
      logic [bfsa_pkg::ADDR_W-1:0] base;
      logic [LEN_W-1:0]            len;
      int                          pick;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= bfsa_pkg::CSR_POOL_BASE;
      csr_data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no pool after reset
      offer_request(bfsa_pkg::OP_ALLOC, '0, '0);
      offer_request(bfsa_pkg::OP_ALLOC, '1, '1);
      offer_request(bfsa_pkg::OP_FREE, '1, '0);
      offer_request(bfsa_pkg::OP_FREE, '0, '1);
      settle();

      // two 32-byte units from the last 32-byte unit of the address space, wrapping to zero
      csr_write(bfsa_pkg::CSR_POOL_BASE, 32'hFFFF_FFE0);
      csr_write(bfsa_pkg::CSR_POOL_SIZE, 32'd64);
      offer_request(bfsa_pkg::OP_ALLOC, '0, '0);
      offer_request(bfsa_pkg::OP_ALLOC, LEN_W'(33), '0);
      offer_request(bfsa_pkg::OP_ALLOC, LEN_W'(1), '0);
      offer_request(bfsa_pkg::OP_ALLOC, '0, '0);
      offer_request(bfsa_pkg::OP_FREE, '0, 32'hFFFF_FFE0);
      offer_request(bfsa_pkg::OP_FREE, '0, 32'hFFFF_FFE0);
      offer_request(bfsa_pkg::OP_ALLOC, '0, '1);
      offer_request(bfsa_pkg::OP_FREE, '0, 32'h0000_0020);
      offer_request(bfsa_pkg::OP_FREE, '0, 32'hFFFF_FFE0);
      offer_request(bfsa_pkg::OP_ALLOC, '0, '0);
      offer_request(bfsa_pkg::OP_FREE, '0, 32'hFFFF_FFE0);
      settle();

      // largest pool, drained by the largest request
      csr_write(bfsa_pkg::CSR_POOL_BASE, '0);
      csr_write(bfsa_pkg::CSR_POOL_SIZE, 32'h0400_0000);
      csr_write(CSR_SPARE_LO, 32'h0000_1000);
      csr_write(CSR_SPARE_HI, 32'h0000_0040);
      offer_request(bfsa_pkg::OP_ALLOC, '1, '0);
      offer_request(bfsa_pkg::OP_ALLOC, LEN_W'(32), '0);
      offer_request(bfsa_pkg::OP_FREE, '0, '0);
      offer_request(bfsa_pkg::OP_ALLOC, LEN_W'(40), '0);
      settle();

      for (int phase = 0; phase < 4; phase++) begin
         calm = (phase == 2);
         base = $urandom();
         base[4:0] = '0;
         pick = $urandom_range(0, 3);
         csr_write(bfsa_pkg::CSR_POOL_BASE, base);
         if (pick == 0) begin
            csr_write(bfsa_pkg::CSR_POOL_SIZE, '0);
         end else if (pick == 3) begin
            csr_write(bfsa_pkg::CSR_POOL_SIZE, 32'h0400_0000);
         end else begin
            csr_write(bfsa_pkg::CSR_POOL_SIZE, $urandom_range(32, 8192));
         end
         csr_write($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom());
         for (int n = 0; n < 400; n++) begin
            addr = $urandom();
            len  = LEN_W'($urandom());
            if ($urandom_range(0, 1) == 0) begin
               pick = $urandom_range(0, 9);
               if (pick < 6) begin
                  len = LEN_W'($urandom_range(0, 256));
               end else if (pick == 8) begin
                  len = '0;
               end else if (pick == 9) begin
                  len = '1;
               end
               offer_request(bfsa_pkg::OP_ALLOC, len, addr);
            end else begin
               if (granted_addrs.size() > 0 && $urandom_range(0, 9) < 7) begin
                  addr = granted_addrs[$urandom_range(0, granted_addrs.size() - 1)];
               end
               offer_request(bfsa_pkg::OP_FREE, len, addr);
            end
         end
         settle();
      end

      if (fail_count == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
